/* rtl/rtr_pkg.sv */
package rtr_pkg;

    // Packed configuration words: three signed 16-bit entries, x in the low bits
    localparam int ENTRY_BITS    = 16;
    localparam int CFG_DATA_BITS = 48;
    localparam int CFG_IDX_BITS  = 3;

    // Result width and the magnitude beyond which an error saturates
    localparam int RES_BITS = 40;
    localparam int MAG_BITS = 28;
    localparam int SQ_BITS  = 2 * MAG_BITS;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROT_ROW_ZERO     = 3'd0,
        CFG_ROT_ROW_ONE      = 3'd1,
        CFG_ROT_ROW_TWO      = 3'd2,
        CFG_TRANSLATION      = 3'd3,
        CFG_INLIER_THRESHOLD = 3'd4
    } t_cfg_idx;

    // Reset values: identity rotation in Q2.14, zero translation and threshold
    localparam logic [CFG_DATA_BITS-1:0] ROT_ROW_ZERO_RST = 48'h0000_0000_4000;
    localparam logic [CFG_DATA_BITS-1:0] ROT_ROW_ONE_RST  = 48'h0000_4000_0000;
    localparam logic [CFG_DATA_BITS-1:0] ROT_ROW_TWO_RST  = 48'h4000_0000_0000;

    // Pick signed entry k out of a packed configuration word
    function automatic logic signed [ENTRY_BITS-1:0] cfg_entry(
        input logic [CFG_DATA_BITS-1:0] word,
        input int unsigned              k
    );
        return word[k*ENTRY_BITS +: ENTRY_BITS];
    endfunction

endpackage

/* rtl/rigid_transform_residual.sv */
// Throughput: one item per cycle while the output is not stalled; an accepted item
// passes nine register stages (capture, products, rounding, differences, magnitudes,
// squares, pair sums, total, clamp and compare), each of which holds one item.
// Each stage has its own valid bit, so a stalled output holds only the stages behind it.
// Reset (synchronous, active low) empties the pipeline and loads the identity rotation,
// zero translation and zero threshold; the configuration port is always ready.
module rigid_transform_residual import rtr_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]           i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]          i_cfg_data,
    // Input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: src_x, src_y, src_z, dst_x, dst_y, dst_z (COORD_BITS each), zero padded
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: residual
    output logic [RES_BITS-1:0]               m_axis_tdata,
    // tuser: is_inlier
    output logic [0:0]                        m_axis_tuser
);

    localparam int VW  = ((COORD_BITS > ENTRY_BITS) ? COORD_BITS : ENTRY_BITS) + 1;
    localparam int PFW = ENTRY_BITS + COORD_BITS;
    localparam int PBW = ENTRY_BITS + VW;

    logic [CFG_DATA_BITS-1:0]     r_rot [3];
    logic [CFG_DATA_BITS-1:0]     r_trans;
    logic [RES_BITS-1:0]          r_thresh;
    logic signed [COORD_BITS-1:0] in_src [3];
    logic signed [COORD_BITS-1:0] in_dst [3];
    logic                         fr_valid;
    logic                         fr_ready;
    logic signed [PFW-1:0]        fr_pf  [9];
    logic signed [PBW-1:0]        fr_pb  [9];
    logic signed [COORD_BITS-1:0] fr_src [3];
    logic signed [COORD_BITS-1:0] fr_dst [3];
    logic                         dt_valid;
    logic                         dt_ready;
    logic [MAG_BITS-1:0]          dt_mag [6];
    logic                         dt_big;
    logic                         sc_inlier;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= ROT_ROW_ZERO_RST;
            r_rot[1] <= ROT_ROW_ONE_RST;
            r_rot[2] <= ROT_ROW_TWO_RST;
            r_trans  <= '0;
            r_thresh <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROT_ROW_ZERO:     r_rot[0] <= i_cfg_data;
                CFG_ROT_ROW_ONE:      r_rot[1] <= i_cfg_data;
                CFG_ROT_ROW_TWO:      r_rot[2] <= i_cfg_data;
                CFG_TRANSLATION:      r_trans  <= i_cfg_data;
                CFG_INLIER_THRESHOLD: r_thresh <= i_cfg_data[RES_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input item
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_src[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            in_dst[i] = s_axis_tdata[(i+3)*COORD_BITS +: COORD_BITS];
        end
    end

    rtr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_src     (in_src),
        .i_dst     (in_dst),
        .i_rot     (r_rot),
        .i_trans   (r_trans),
        .o_valid   (fr_valid),
        .i_ready   (fr_ready),
        .o_prod_fw (fr_pf),
        .o_prod_bw (fr_pb),
        .o_src     (fr_src),
        .o_dst     (fr_dst)
    );

    rtr_dot #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (fr_valid),
        .o_ready   (fr_ready),
        .i_prod_fw (fr_pf),
        .i_prod_bw (fr_pb),
        .i_src     (fr_src),
        .i_dst     (fr_dst),
        .i_trans   (r_trans),
        .o_valid   (dt_valid),
        .i_ready   (dt_ready),
        .o_mag     (dt_mag),
        .o_big     (dt_big)
    );

    rtr_score u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dt_valid),
        .o_ready     (dt_ready),
        .i_mag       (dt_mag),
        .i_big       (dt_big),
        .i_threshold (r_thresh),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_residual  (m_axis_tdata),
        .o_inlier    (sc_inlier)
    );

    assign m_axis_tuser = sc_inlier;

endmodule

/* rtl/rtr_front.sv */
// Input capture, destination minus translation, and the eighteen row products
module rtr_front import rtr_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_src [3],
    input  logic signed [COORD_BITS-1:0]  i_dst [3],
    input  logic [CFG_DATA_BITS-1:0]      i_rot [3],
    input  logic [CFG_DATA_BITS-1:0]      i_trans,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ENTRY_BITS+COORD_BITS-1:0] o_prod_fw [9],
    output logic signed [ENTRY_BITS+((COORD_BITS > ENTRY_BITS) ? COORD_BITS : ENTRY_BITS):0]
                                          o_prod_bw [9],
    output logic signed [COORD_BITS-1:0]  o_src [3],
    output logic signed [COORD_BITS-1:0]  o_dst [3]
);

    localparam int VW  = ((COORD_BITS > ENTRY_BITS) ? COORD_BITS : ENTRY_BITS) + 1;
    localparam int PFW = ENTRY_BITS + COORD_BITS;
    localparam int PBW = ENTRY_BITS + VW;

    logic [1:0]                  r_vld;
    logic [1:0]                  rdy;
    logic signed [COORD_BITS-1:0] r_s1_src [3];
    logic signed [COORD_BITS-1:0] r_s1_dst [3];
    logic signed [VW-1:0]         r_s1_v   [3];
    logic signed [VW-1:0]         n_s1_v   [3];
    logic signed [PFW-1:0]        n_pf     [9];
    logic signed [PBW-1:0]        n_pb     [9];
    logic signed [PFW-1:0]        r_pf     [9];
    logic signed [PBW-1:0]        r_pb     [9];
    logic signed [COORD_BITS-1:0] r_s2_src [3];
    logic signed [COORD_BITS-1:0] r_s2_dst [3];

    // Stage k loads when it is empty or its item moves on
    always_comb begin
        rdy[1] = !r_vld[1] || i_ready;
        rdy[0] = !r_vld[0] || rdy[1];
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    // Destination point moved back by the translation
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_v[i] = VW'(i_dst[i]) - VW'(cfg_entry(i_trans, i));
        end
    end

    // Forward products R[i][j]*src[j], backward products R[j][i]*v[j]
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pf[i*3+j] = PFW'(cfg_entry(i_rot[i], j)) * PFW'(r_s1_src[j]);
                n_pb[i*3+j] = PBW'(cfg_entry(i_rot[j], i)) * PBW'(r_s1_v[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1_src <= i_src;
            r_s1_dst <= i_dst;
            r_s1_v   <= n_s1_v;
        end
        if (rdy[1]) begin
            r_pf     <= n_pf;
            r_pb     <= n_pb;
            r_s2_src <= r_s1_src;
            r_s2_dst <= r_s1_dst;
        end
    end

    assign o_prod_fw = r_pf;
    assign o_prod_bw = r_pb;
    assign o_src     = r_s2_src;
    assign o_dst     = r_s2_dst;

endmodule

/* rtl/rtr_dot.sv */
// Row sums with rounding, coordinate differences, and error magnitudes
module rtr_dot import rtr_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ENTRY_BITS+COORD_BITS-1:0] i_prod_fw [9],
    input  logic signed [ENTRY_BITS+((COORD_BITS > ENTRY_BITS) ? COORD_BITS : ENTRY_BITS):0]
                                          i_prod_bw [9],
    input  logic signed [COORD_BITS-1:0]  i_src [3],
    input  logic signed [COORD_BITS-1:0]  i_dst [3],
    input  logic [CFG_DATA_BITS-1:0]      i_trans,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [MAG_BITS-1:0]           o_mag [6],
    output logic                          o_big
);

    localparam int VW  = ((COORD_BITS > ENTRY_BITS) ? COORD_BITS : ENTRY_BITS) + 1;
    localparam int PFW = ENTRY_BITS + COORD_BITS;
    localparam int PBW = ENTRY_BITS + VW;
    localparam int SFW = PFW + 2;
    localparam int SBW = PBW + 2;
    localparam int DW  = PBW + 4;

    localparam logic [SFW-1:0] RND_F = SFW'(1) << (FRAC_BITS - 1);
    localparam logic [SBW-1:0] RND_B = SBW'(1) << (FRAC_BITS - 1);

    logic [2:0]                   r_vld;
    logic [2:0]                   rdy;
    logic signed [SFW-1:0]        n_fw     [3];
    logic signed [SBW-1:0]        n_bw     [3];
    logic signed [SFW-1:0]        r_fw     [3];
    logic signed [SBW-1:0]        r_bw     [3];
    logic signed [COORD_BITS-1:0] r_s3_src [3];
    logic signed [COORD_BITS-1:0] r_s3_dst [3];
    logic signed [DW-1:0]         n_err    [6];
    logic signed [DW-1:0]         r_err    [6];
    logic [DW-1:0]                abs_err  [6];
    logic [MAG_BITS-1:0]          n_mag    [6];
    logic                         n_big;
    logic [MAG_BITS-1:0]          r_mag    [6];
    logic                         r_big;

    always_comb begin
        rdy[2] = !r_vld[2] || i_ready;
        rdy[1] = !r_vld[1] || rdy[2];
        rdy[0] = !r_vld[0] || rdy[1];
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Sum each row, round half up at the binary point
    always_comb begin
        logic signed [SFW-1:0] acc_f;
        logic signed [SBW-1:0] acc_b;
        for (int i = 0; i < 3; i++) begin
            acc_f = SFW'(i_prod_fw[i*3]) + SFW'(i_prod_fw[i*3+1])
                  + SFW'(i_prod_fw[i*3+2]) + $signed(RND_F);
            acc_b = SBW'(i_prod_bw[i*3]) + SBW'(i_prod_bw[i*3+1])
                  + SBW'(i_prod_bw[i*3+2]) + $signed(RND_B);
            n_fw[i] = acc_f >>> FRAC_BITS;
            n_bw[i] = acc_b >>> FRAC_BITS;
        end
    end

    // Forward error dst - (fw + t), backward error src - bw
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_err[2*i]   = DW'(r_s3_dst[i]) - DW'(r_fw[i]) - DW'(cfg_entry(i_trans, i));
            n_err[2*i+1] = DW'(r_s3_src[i]) - DW'(r_bw[i]);
        end
    end

    // Magnitudes; flag any that is too large to square within range
    always_comb begin
        n_big = 1'b0;
        for (int k = 0; k < 6; k++) begin
            abs_err[k] = r_err[k][DW-1] ? DW'(-r_err[k]) : DW'(r_err[k]);
            n_mag[k]   = abs_err[k][MAG_BITS-1:0];
            if (abs_err[k][DW-1:MAG_BITS] != '0) n_big = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_fw     <= n_fw;
            r_bw     <= n_bw;
            r_s3_src <= i_src;
            r_s3_dst <= i_dst;
        end
        if (rdy[1]) begin
            r_err <= n_err;
        end
        if (rdy[2]) begin
            r_mag <= n_mag;
            r_big <= n_big;
        end
    end

    assign o_mag = r_mag;
    assign o_big = r_big;

endmodule

/* rtl/rtr_score.sv */
// Squares, saturating sum, and the inlier compare
module rtr_score import rtr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [MAG_BITS-1:0]  i_mag [6],
    input  logic                 i_big,
    input  logic [RES_BITS-1:0]  i_threshold,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [RES_BITS-1:0]  o_residual,
    output logic                 o_inlier
);

    localparam int PSW = RES_BITS + 1;
    localparam int TSW = RES_BITS + 3;

    logic [3:0]              r_vld;
    logic [3:0]              rdy;
    logic [SQ_BITS-1:0]      r_sq [6];
    logic                    r_s6_big;
    logic [PSW-1:0]          n_ps [3];
    logic                    n_s7_sat;
    logic [PSW-1:0]          r_ps [3];
    logic                    r_s7_sat;
    logic [TSW-1:0]          r_tot;
    logic                    r_s8_sat;
    logic [RES_BITS-1:0]     n_res;
    logic [RES_BITS-1:0]     r_res;
    logic                    r_inl;

    always_comb begin
        rdy[3] = !r_vld[3] || i_ready;
        rdy[2] = !r_vld[2] || rdy[3];
        rdy[1] = !r_vld[1] || rdy[2];
        rdy[0] = !r_vld[0] || rdy[1];
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Pairwise sums; a square at or above the result range saturates
    always_comb begin
        n_s7_sat = r_s6_big;
        for (int p = 0; p < 3; p++) begin
            n_ps[p] = PSW'(r_sq[2*p][RES_BITS-1:0]) + PSW'(r_sq[2*p+1][RES_BITS-1:0]);
            if (r_sq[2*p][SQ_BITS-1:RES_BITS] != '0 ||
                r_sq[2*p+1][SQ_BITS-1:RES_BITS] != '0) begin
                n_s7_sat = 1'b1;
            end
        end
    end

    // Clamp the total to the result range
    assign n_res = (r_s8_sat || r_tot[TSW-1:RES_BITS] != '0) ? '1 : r_tot[RES_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int k = 0; k < 6; k++) begin
                r_sq[k] <= SQ_BITS'(i_mag[k]) * SQ_BITS'(i_mag[k]);
            end
            r_s6_big <= i_big;
        end
        if (rdy[1]) begin
            r_ps     <= n_ps;
            r_s7_sat <= n_s7_sat;
        end
        if (rdy[2]) begin
            r_tot    <= TSW'(r_ps[0]) + TSW'(r_ps[1]) + TSW'(r_ps[2]);
            r_s8_sat <= r_s7_sat;
        end
        if (rdy[3]) begin
            r_res <= n_res;
            r_inl <= (n_res < i_threshold);
        end
    end

    assign o_residual = r_res;
    assign o_inlier   = r_inl;

endmodule

/* test/tb_rigid_transform_residual.sv */
`timescale 1ns / 100ps

module tb_rigid_transform_residual;
    import rtr_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;
    localparam int TAIL_CYCLES = 12;
    localparam int TIMEOUT_NS  = 10_000_000;
    localparam int MAX_REPORTS = 40;

    // Indexes beyond the register list; writes to them must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOP    = 3'd7;

    localparam logic [63:0] RES_MAX  = (64'd1 << RES_BITS) - 64'd1;
    localparam longint      DIFF_CAP = longint'(1) << MAG_BITS;

    // Coordinates 0..2 are src x/y/z, 3..5 are dst x/y/z; element 0 sits in the low bits
    typedef logic [5:0][COORD_BITS-1:0] pair_t;

    typedef struct packed {
        logic [RES_BITS-1:0] residual;
        logic                inlier;
    } score_t;

    typedef struct {
        bit                       is_cfg;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] dat;
        pair_t                    pair;
        bit                       typed;
        score_t                   want;
    } step_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     cfg_ready;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [6*COORD_BITS-1:0]  in_data  = '0;

    logic                     out_valid;
    logic                     out_ready = 1'b1;
    logic [RES_BITS-1:0]      out_residual;
    logic [0:0]               out_inlier;

    // Mirror of the hypothesis registers
    logic [CFG_DATA_BITS-1:0] rot_rows [3];
    logic [CFG_DATA_BITS-1:0] trans_word;
    logic [RES_BITS-1:0]      inlier_limit;

    score_t pending_scores [$];
    step_t  dir_steps [$];
    int     errors     = 0;
    int     stall_left = 0;
    bit     gaps_on    = 1'b1;
    bit     stalls_on  = 1'b1;

    rigid_transform_residual #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(in_valid),
        .s_axis_tready(in_ready),
        .s_axis_tdata (in_data),
        .m_axis_tvalid(out_valid),
        .m_axis_tready(out_ready),
        .m_axis_tdata (out_residual),
        .m_axis_tuser (out_inlier)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Signed entry k of a packed register word
    function automatic longint entry_of(logic [CFG_DATA_BITS-1:0] w, int k);
        return longint'($signed(w[k*ENTRY_BITS +: ENTRY_BITS]));
    endfunction

    function automatic longint coord_of(pair_t p, int k);
        return longint'($signed(p[k]));
    endfunction

    // Round half up at the binary point: floor(x / 2^F + 1/2)
    function automatic longint round_half_up(longint x);
        return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Forward-mapped coordinate i: row i of R times src, rounded, plus t
    function automatic longint map_row(int i, pair_t p);
        longint acc;
        acc = 0;
        for (int j = 0; j < 3; j++)
            acc += entry_of(rot_rows[i], j) * coord_of(p, j);
        return round_half_up(acc) + entry_of(trans_word, i);
    endfunction

    // Symmetric transfer error of one pair under the mirrored hypothesis
    function automatic score_t score_pair(pair_t p);
        longint      back, e;
        longint      diffs [2];
        logic [63:0] acc;
        bit          ok;
        score_t      s;
        acc = 0;
        ok  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            back = 0;
            for (int j = 0; j < 3; j++)
                back += entry_of(rot_rows[j], i) * (coord_of(p, 3 + j) - entry_of(trans_word, j));
            diffs[0] = coord_of(p, 3 + i) - map_row(i, p);
            diffs[1] = coord_of(p, i) - round_half_up(back);
            foreach (diffs[k]) begin
                e = diffs[k] < 0 ? -diffs[k] : diffs[k];
                if (ok && e >= DIFF_CAP)
                    ok = 1'b0;
                else if (ok)
                    acc += 64'(e * e);
            end
        end
        if (!ok || acc > RES_MAX)
            acc = RES_MAX;
        s.residual = acc[RES_BITS-1:0];
        s.inlier   = acc < 64'(inlier_limit);
        return s;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_BITS-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Q2.14 entry: wild over the full range, or close to a signed unit on the diagonal
    function automatic logic [ENTRY_BITS-1:0] rand_entry(bit wild, bit diag);
        int v;
        if (wild)
            return ENTRY_BITS'($urandom);
        v = int'($urandom_range(600)) - 300;
        if (diag)
            v += $urandom_range(1) ? 16384 : -16384;
        return ENTRY_BITS'(v);
    endfunction

    function automatic step_t item_row(int sx, int sy, int sz, int dx, int dy, int dz);
        step_t r;
        r = '{default: '0};
        r.pair[0] = COORD_BITS'(sx);
        r.pair[1] = COORD_BITS'(sy);
        r.pair[2] = COORD_BITS'(sz);
        r.pair[3] = COORD_BITS'(dx);
        r.pair[4] = COORD_BITS'(dy);
        r.pair[5] = COORD_BITS'(dz);
        return r;
    endfunction

    function automatic step_t checked_row(int sx, int sy, int sz, int dx, int dy, int dz,
                                          logic [RES_BITS-1:0] res, bit inl);
        step_t r;
        r = item_row(sx, sy, sz, dx, dy, dz);
        r.typed         = 1'b1;
        r.want.residual = res;
        r.want.inlier   = inl;
        return r;
    endfunction

    function automatic step_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] dat);
        step_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.dat    = dat;
        return r;
    endfunction

    // Random pair: mostly a near-match of the hypothesis, some noise and extremes
    function automatic pair_t make_pair();
        pair_t  p;
        longint v;
        int     kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            for (int i = 0; i < 3; i++)
                p[i] = $urandom_range(1) ? COORD_BITS'($urandom)
                                         : COORD_BITS'(int'($urandom_range(2000)) - 1000);
            for (int i = 0; i < 3; i++) begin
                v = map_row(i, p) + int'($urandom_range(8)) - 4;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                p[3 + i] = COORD_BITS'(v);
            end
        end else if (kind < 95) begin
            p = {$urandom, $urandom, $urandom};
        end else begin
            for (int i = 0; i < 6; i++)
                case ($urandom_range(3))
                    0: p[i] = 16'h8000;
                    1: p[i] = 16'h7FFF;
                    2: p[i] = 16'h0000;
                    default: p[i] = 16'hFFFF;
                endcase
        end
        return p;
    endfunction

    // Write one register; valid stays high so that writes can follow back to back
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] dat);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= dat;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROT_ROW_ZERO:     rot_rows[0]  = dat;
            CFG_ROT_ROW_ONE:      rot_rows[1]  = dat;
            CFG_ROT_ROW_TWO:      rot_rows[2]  = dat;
            CFG_TRANSLATION:      trans_word   = dat;
            CFG_INLIER_THRESHOLD: inlier_limit = dat[RES_BITS-1:0];
            default: ;
        endcase
    endtask

    // Offer one pair, record its expected score on acceptance, then maybe idle
    task automatic send_item(pair_t p, bit typed, score_t want);
        int gap;
        cfg_valid <= 1'b0;
        in_valid  <= 1'b1;
        in_data   <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_scores.push_back(typed ? want : score_pair(p));
        gap = (gaps_on && $urandom_range(99) < 30) ? gap_len() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold input off until every expected score has come back
    task automatic drain_scores();
        cfg_valid <= 1'b0;
        in_valid  <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, short mostly, off in some phases
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (stalls_on && $urandom_range(99) < 25) begin
            stall_left <= gap_len() - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready  <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected score
    always @(posedge clk) begin : check_scores
        score_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_scores.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result: residual %0d inlier %0d",
                             $time, out_residual, out_inlier[0]);
                errors++;
            end else begin
                want = pending_scores.pop_front();
                if (out_residual !== want.residual) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: residual mismatch: expected %0d actual %0d",
                                 $time, want.residual, out_residual);
                    errors++;
                end
                if (out_inlier[0] !== want.inlier) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: inlier mismatch: expected %0d actual %0d",
                                 $time, want.inlier, out_inlier[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [CFG_DATA_BITS-1:0] row0, row1, row2;
        bit                       wild;

        rot_rows[0]  = ROT_ROW_ZERO_RST;
        rot_rows[1]  = ROT_ROW_ONE_RST;
        rot_rows[2]  = ROT_ROW_TWO_RST;
        trans_word   = '0;
        inlier_limit = '0;

        // Identity, zero translation and zero threshold after reset:
        // residual is 2*|dst-src|^2 and nothing is an inlier
        dir_steps.push_back(checked_row(0, 0, 0, 0, 0, 0, 40'd0, 1'b0));
        dir_steps.push_back(checked_row(1, 0, 0, 0, 0, 0, 40'd2, 1'b0));
        dir_steps.push_back(checked_row(32767, 32767, 32767, -32768, -32768, -32768,
                                        40'd25769017350, 1'b0));
        dir_steps.push_back(checked_row(-32768, -32768, -32768, 32767, 32767, 32767,
                                        40'd25769017350, 1'b0));
        dir_steps.push_back(checked_row(-32768, 32767, 0, 32767, -32768, 0,
                                        40'd17179344900, 1'b0));
        dir_steps.push_back(checked_row(32767, 32767, 32767, 32767, 32767, 32767, 40'd0, 1'b0));
        // Threshold boundary: strictly below is an inlier
        dir_steps.push_back(cfg_row(CFG_INLIER_THRESHOLD, 48'd2));
        dir_steps.push_back(checked_row(0, 1, 0, 0, 0, 0, 40'd2, 1'b0));
        dir_steps.push_back(cfg_row(CFG_INLIER_THRESHOLD, 48'd3));
        dir_steps.push_back(checked_row(0, 0, 0, 0, 0, -1, 40'd2, 1'b1));
        // Threshold with high bits beyond its width: only the low 40 bits count
        dir_steps.push_back(cfg_row(CFG_INLIER_THRESHOLD, 48'hFFFF_FFFF_FFFF));
        dir_steps.push_back(checked_row(32767, 32767, 32767, -32768, -32768, -32768,
                                        40'd25769017350, 1'b1));
        // Writes past the register list leave everything as it was
        dir_steps.push_back(cfg_row(CFG_IDX_UNUSED, 48'hFFFF_FFFF_FFFF));
        dir_steps.push_back(cfg_row(CFG_IDX_TOP, 48'h8000_8000_8000));
        dir_steps.push_back(checked_row(0, 0, 0, 0, 0, 0, 40'd0, 1'b1));
        // Half-unit rotation entry: ties round up
        dir_steps.push_back(cfg_row(CFG_ROT_ROW_ZERO, 48'h0000_0000_2000));
        dir_steps.push_back(item_row(1, 0, 0, 1, 0, 0));
        dir_steps.push_back(item_row(-1, 0, 0, 0, 0, 0));
        dir_steps.push_back(item_row(3, -5, 7, -3, 2, 9));
        // Most negative rotation and translation entries
        dir_steps.push_back(cfg_row(CFG_ROT_ROW_ZERO, 48'h8000_8000_8000));
        dir_steps.push_back(cfg_row(CFG_ROT_ROW_ONE, 48'h8000_8000_8000));
        dir_steps.push_back(cfg_row(CFG_ROT_ROW_TWO, 48'h8000_8000_8000));
        dir_steps.push_back(cfg_row(CFG_TRANSLATION, 48'h8000_8000_8000));
        dir_steps.push_back(item_row(32767, 32767, 32767, 32767, 32767, 32767));
        dir_steps.push_back(item_row(-32768, 32767, -32768, 32767, -32768, 32767));
        // Largest positive translation
        dir_steps.push_back(cfg_row(CFG_TRANSLATION, 48'h7FFF_7FFF_7FFF));
        dir_steps.push_back(item_row(32767, 32767, 32767, -32768, -32768, -32768));
        dir_steps.push_back(item_row(-32768, -32768, -32768, 32767, 32767, 32767));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_steps[k]) begin
            if (dir_steps[k].is_cfg) begin
                drain_scores();
                cfg_write(dir_steps[k].idx, dir_steps[k].dat);
            end else begin
                send_item(dir_steps[k].pair, dir_steps[k].typed, dir_steps[k].want);
            end
        end

        // Random phases, each under a fresh hypothesis
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_scores();
            gaps_on   = (ph != 3);
            stalls_on = (ph != 3 && ph != 6);
            if (ph == 0) begin
                row0 = 48'h7FFF_7FFF_7FFF;
                row1 = 48'h7FFF_7FFF_7FFF;
                row2 = 48'h7FFF_7FFF_7FFF;
                cfg_write(CFG_TRANSLATION, 48'h7FFF_7FFF_7FFF);
                cfg_write(CFG_INLIER_THRESHOLD, 48'hFFFF_FFFF_FFFF);
            end else if (ph == 1) begin
                row0 = 48'h8000_8000_8000;
                row1 = 48'h8000_8000_8000;
                row2 = 48'h8000_8000_8000;
                cfg_write(CFG_TRANSLATION, 48'h8000_8000_8000);
                cfg_write(CFG_INLIER_THRESHOLD, 48'h0);
            end else begin
                wild = ($urandom_range(3) == 0);
                row0 = {rand_entry(wild, 0), rand_entry(wild, 0), rand_entry(wild, 1)};
                row1 = {rand_entry(wild, 0), rand_entry(wild, 1), rand_entry(wild, 0)};
                row2 = {rand_entry(wild, 1), rand_entry(wild, 0), rand_entry(wild, 0)};
                cfg_write(CFG_TRANSLATION, wild ? rand48()
                          : {rand_entry(0, 0), rand_entry(0, 0), rand_entry(0, 0)});
                case ($urandom_range(3))
                    0: cfg_write(CFG_INLIER_THRESHOLD, rand48());
                    1: cfg_write(CFG_INLIER_THRESHOLD, 48'h0);
                    default: cfg_write(CFG_INLIER_THRESHOLD, 48'($urandom_range(2000000)));
                endcase
            end
            cfg_write(CFG_ROT_ROW_ZERO, row0);
            cfg_write(CFG_IDX_UNUSED, rand48());
            cfg_write(CFG_ROT_ROW_ONE, row1);
            cfg_write(CFG_ROT_ROW_TWO, row2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(make_pair(), 1'b0, '0);
        end

        // Wait out the pipeline, then report
        drain_scores();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_scores.size() == 0)
            $display("tb_rigid_transform_residual: PASS");
        else
            $display("tb_rigid_transform_residual: FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("tb_rigid_transform_residual: FAIL");
        $finish;
    end

endmodule
